// ----- rtl/core/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

  // Fixed field widths
  localparam int VALUE_BITS = 8;
  localparam int CFG_BITS   = 7;

  // Status a cell reports to the row
  typedef struct packed {
    logic del;   // this cell holds the expiring sample
    logic gt;    // empty, or value above the incoming sample
  } cell_stat_t;

  // What a cell sees of its neighbors
  typedef struct packed {
    logic sh_left;   // deletion at or below the left neighbor
    logic sh_self;   // deletion at or below this cell
    logic gt_left;   // left neighbor above the incoming sample (0 for the first cell)
    logic gt_right;  // right neighbor above the incoming sample (1 for the last cell)
  } cell_nbr_t;

endpackage

// ----- rtl/core/swm_cell.sv -----
`timescale 1ns / 1ps

module swm_cell #(
  parameter int AGE_BITS = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clear,
  input  logic                                 advance,
  input  logic [swm_pkg::VALUE_BITS-1:0]       sample,
  input  logic                                 full,
  input  logic [AGE_BITS-1:0]                  age_last,
  input  logic [swm_pkg::VALUE_BITS+AGE_BITS:0] left_ent,
  input  logic [swm_pkg::VALUE_BITS+AGE_BITS:0] right_ent,
  input  swm_pkg::cell_nbr_t                   nbr,
  output logic [swm_pkg::VALUE_BITS+AGE_BITS:0] ent,
  output swm_pkg::cell_stat_t                  stat
);

  localparam int VB = swm_pkg::VALUE_BITS;
  localparam int EW = 1 + VB + AGE_BITS;

  logic                valid;
  logic [VB-1:0]       value;
  logic [AGE_BITS-1:0] age;

  logic [EW-1:0]       d_self;
  logic [EW-1:0]       d_left;
  logic                gd_self;
  logic                gd_left;
  logic                valid_next;
  logic [VB-1:0]       value_next;
  logic [AGE_BITS-1:0] age_next;

  assign ent = {valid, value, age};

  // Local compare against the incoming sample and expiry check
  assign stat.gt  = !valid || (value > sample);
  assign stat.del = full && valid && (age == age_last);

  // Row as it stands once the expiring entry is taken out
  assign d_self  = nbr.sh_self ? right_ent : ent;
  assign gd_self = nbr.sh_self ? nbr.gt_right : stat.gt;
  assign d_left  = nbr.sh_left ? ent : left_ent;
  assign gd_left = nbr.sh_left ? stat.gt : nbr.gt_left;

  // Sorted insert: keep, take the new sample, or take the left entry
  always_comb begin
    if (!gd_self) begin
      valid_next = d_self[EW-1];
      value_next = d_self[EW-2 -: VB];
      age_next   = d_self[AGE_BITS-1:0] + 1'b1;
    end else if (!gd_left) begin
      valid_next = 1'b1;
      value_next = sample;
      age_next   = '0;
    end else begin
      valid_next = d_left[EW-1];
      value_next = d_left[EW-2 -: VB];
      age_next   = d_left[AGE_BITS-1:0] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      value <= value_next;
      age   <= age_next;
    end
  end

endmodule

// ----- rtl/core/sliding_window_median_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Payload
// s_*       in         s_tvalid/s_tready/s_tdata      sample
// m_*       out        m_tvalid/m_tready/m_tdata      median
// cfg_*     in         cfg_wr_en/cfg_wr_data          window_size
//
// One sample per cycle while s_tready is high. The window lives in a row of
// WINDOW_MAX cells kept in ascending order; each request removes the expiring
// entry and inserts the new one in that same cycle. The median is marked
// pending, then loaded into an output register once it is free. Synchronous
// reset empties the row and sets the window to 64 (or WINDOW_MAX if smaller).
// A stalled output holds back at most one further request.

module sliding_window_median_core #(
  parameter int WINDOW_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] sample
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] median
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data
);

  localparam int VB       = swm_pkg::VALUE_BITS;
  localparam int AGE_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int KW       = $clog2(WINDOW_MAX + 1);
  localparam int EW       = 1 + VB + AGE_BITS;
  localparam int RESET_K  = (WINDOW_MAX < 64) ? WINDOW_MAX : 64;

  logic [KW-1:0]         k;
  logic [KW-1:0]         seen;
  logic                  pend;
  logic [VB-1:0]         median;

  logic [KW-1:0]         k_next;
  logic [31:0]           cfg_ext;
  logic                  full;
  logic                  produces;
  logic                  can_load;
  logic                  accept;
  logic [AGE_BITS-1:0]   age_last;
  logic [AGE_BITS-1:0]   mid;
  logic [WINDOW_MAX-1:0] del_vec;
  logic [WINDOW_MAX-1:0] gt_vec;
  logic [WINDOW_MAX-1:0] valid_vec;
  logic [WINDOW_MAX-1:0] sh_vec;
  logic [EW-1:0]         ent [WINDOW_MAX];

  // Handshake
  assign can_load = !m_tvalid || m_tready;
  assign s_tready = !pend || can_load;
  assign accept   = s_tvalid && s_tready;

  assign full     = (seen == k);
  assign produces = full || (KW'(seen + 1'b1) == k);
  assign age_last = AGE_BITS'(k - 1'b1);
  assign mid      = AGE_BITS'(k >> 1);

  // Window size clamp on write
  assign cfg_ext = 32'(cfg_wr_data);
  always_comb begin
    if (cfg_ext == 32'd0) begin
      k_next = KW'(1);
    end else if (cfg_ext > 32'(WINDOW_MAX)) begin
      k_next = KW'(WINDOW_MAX);
    end else begin
      k_next = KW'(cfg_ext);
    end
  end

  // Deletion shift flags: prefix OR of the one-hot expiry vector
  always_comb begin
    sh_vec = del_vec;
    for (int s = 0; s < AGE_BITS; s++) begin
      sh_vec = sh_vec | (sh_vec << (1 << s));
    end
  end

  // Row of cells
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_pkg::cell_stat_t stat;
    swm_pkg::cell_nbr_t  nbr;
    logic [EW-1:0]       left_ent;
    logic [EW-1:0]       right_ent;

    if (i == 0) begin : g_first
      assign left_ent    = '0;
      assign nbr.sh_left = 1'b0;
      assign nbr.gt_left = 1'b0;
    end else begin : g_inner_l
      assign left_ent    = ent[i-1];
      assign nbr.sh_left = sh_vec[i-1];
      assign nbr.gt_left = gt_vec[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign right_ent    = '0;
      assign nbr.gt_right = 1'b1;
    end else begin : g_inner_r
      assign right_ent    = ent[i+1];
      assign nbr.gt_right = gt_vec[i+1];
    end

    assign nbr.sh_self = sh_vec[i];
    assign del_vec[i]  = stat.del;
    assign gt_vec[i]   = stat.gt;
    assign valid_vec[i] = ent[i][EW-1];

    swm_cell #(
      .AGE_BITS(AGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .clear    (cfg_wr_en),
      .advance  (accept),
      .sample   (s_tdata),
      .full     (full),
      .age_last (age_last),
      .left_ent (left_ent),
      .right_ent(right_ent),
      .ent      (ent[i]),
      .nbr      (nbr),
      .stat     (stat)
    );
  end

  // Median tap: element of rank k/2+1
  assign median = ent[mid][EW-2 -: VB];

  // Window size and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= KW'(RESET_K);
      seen <= '0;
    end else if (cfg_wr_en) begin
      k    <= k_next;
      seen <= '0;
    end else if (accept && !full) begin
      seen <= KW'(seen + 1'b1);
    end
  end

  // Pending median and output register
  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      pend <= 1'b0;
    end else if (accept) begin
      pend <= produces;
    end else if (can_load) begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pend && can_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend && can_load) begin
      m_tdata <= median;
    end
  end

  // Checks
  a_fill_count : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(seen))
    else $error("occupied cells differ from fill count");

  a_one_expiry : assert property (@(posedge clk) disable iff (rst)
    $onehot0(del_vec))
    else $error("more than one cell expiring");

  a_pend_full : assert property (@(posedge clk) disable iff (rst)
    pend |-> full)
    else $error("median pending with window not full");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int WIN_MAX = 64;
  localparam int LEVELS  = 1 << swm_pkg::VALUE_BITS;

  typedef logic [swm_pkg::VALUE_BITS-1:0] sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  sample_t                      s_tdata = '0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  sample_t                      m_tdata;
  logic                         cfg_wr_en = 1'b0;
  logic [swm_pkg::CFG_BITS-1:0] cfg_wr_data = '0;

  sliding_window_median_core #(.WINDOW_MAX(WIN_MAX)) dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),     // [7:0] sample
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),     // [7:0] median
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock, 8 ns period
  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow of the filter window
  int      win_len;
  sample_t delay_line [WIN_MAX];
  int      hist [LEVELS];
  int      wr_slot;
  int      fill_level;

  sample_t sample_q [$];    // samples waiting to be sent
  sample_t median_q [$];    // medians expected from the block

  int  errors        = 0;
  int  samples_sent  = 0;
  int  medians_seen  = 0;
  int  settings_used = 0;
  int  win_min       = WIN_MAX;
  int  win_max_used  = 0;
  bit  steady        = 1'b0;   // no idling on either side while set

  // Empty the window and take a new length (0 acts as 1, above max acts as max)
  function automatic void set_window(int raw);
    win_len = (raw < 1) ? 1 : (raw > WIN_MAX) ? WIN_MAX : raw;
    foreach (delay_line[i]) delay_line[i] = '0;
    foreach (hist[i]) hist[i] = 0;
    wr_slot    = 0;
    fill_level = 0;
    if (win_len < win_min) win_min = win_len;
    if (win_len > win_max_used) win_max_used = win_len;
    settings_used++;
  endfunction

  // Slide the window by one sample; returns the median or -1 while filling
  function automatic int slide_median(sample_t smp);
    int old_slot;
    int rank;
    int acc;
    hist[smp]++;
    if (fill_level >= win_len) begin
      old_slot = (wr_slot + WIN_MAX - win_len) % WIN_MAX;
      if (hist[delay_line[old_slot]] > 0) hist[delay_line[old_slot]]--;
    end else begin
      fill_level++;
    end
    delay_line[wr_slot] = smp;
    wr_slot = (wr_slot + 1) % WIN_MAX;
    if (fill_level < win_len) return -1;
    rank = fill_level / 2 + 1;
    acc  = 0;
    for (int v = 0; v < LEVELS; v++) begin
      acc += hist[v];
      if (acc >= rank) return v;
    end
    return -1;
  endfunction

  // Driver: one request per cycle from sample_q while s_tready is high, random gaps
  always @(posedge clk) begin
    int med;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        samples_sent++;
        med = slide_median(s_tdata);
        if (med >= 0) median_q.push_back(sample_t'(med));
      end
      if (!s_tvalid || s_tready) begin
        if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= 28)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= sample_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure, compare each median in order
  always @(posedge clk) begin
    sample_t exp_med;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (median_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected median: expected none, actual %0d", $time, m_tdata);
        end else begin
          exp_med = median_q.pop_front();
          medians_seen++;
          if (m_tdata !== exp_med) begin
            errors++;
            $display("%0t: median mismatch: expected %0d, actual %0d",
                     $time, exp_med, m_tdata);
          end
        end
      end
      m_tready <= steady || ($urandom_range(0, 99) >= 28);
    end
  end

  // Wait until nothing is in flight (checked mid-cycle, once the edge has settled),
  // then let the output stage drain
  task automatic wait_drained();
    while (sample_q.size() != 0 || s_tvalid || median_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_window(int raw);
    wait_drained();
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= swm_pkg::CFG_BITS'(raw);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    set_window(raw);
  endtask

  function automatic sample_t pick_sample(int mode, int base, int idx);
    int v;
    case (mode)
      0: v = $urandom_range(0, LEVELS - 1);
      1: v = base + $urandom_range(0, 14) - 7;                  // tight cluster, many ties
      2: v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, LEVELS - 1)
                                         : (($urandom_range(0, 1) == 1) ? LEVELS - 1 : 0);
      default: v = base + idx * 3 + $urandom_range(0, 4);       // ramp with noise
    endcase
    if (v < 0) v = 0;
    return sample_t'(v % LEVELS);
  endfunction

  // Stimulus and phase control
  initial begin
    int rand_items;
    int phase;
    int raw;
    int eff;
    int n;
    int mode;
    int base;
    rand_items = 0;
    phase      = 0;
    set_window(64);
    settings_used = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Partial fill at the reset length, dropped by the next write
    sample_q.push_back(8'd0);
    sample_q.push_back(8'd255);
    // Length one: every sample is its own median
    write_window(1);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd255); sample_q.push_back(8'd85);
    sample_q.push_back(8'd170); sample_q.push_back(8'd1);   sample_q.push_back(8'd128);
    // Zero written acts as one
    write_window(0);
    sample_q.push_back(8'd3);
    sample_q.push_back(8'd200);
    // Even length takes the upper median
    write_window(2);
    sample_q.push_back(8'd10);  sample_q.push_back(8'd250); sample_q.push_back(8'd250);
    sample_q.push_back(8'd0);   sample_q.push_back(8'd0);
    write_window(3);
    sample_q.push_back(8'd255); sample_q.push_back(8'd0);   sample_q.push_back(8'd128);
    sample_q.push_back(8'd7);   sample_q.push_back(8'd7);
    // Oversized length clamps to max; left partly filled when rewritten
    write_window(127);
    sample_q.push_back(8'd9);   sample_q.push_back(8'd250);

    // Random phases
    while (rand_items < 1000) begin
      case ($urandom_range(0, 9))
        0:       raw = 0;
        1:       raw = 1;
        2:       raw = 64;
        3:       raw = $urandom_range(65, 127);
        default: raw = $urandom_range(2, 63);
      endcase
      write_window(raw);
      eff = win_len;
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, eff - 1);
      else n = eff + $urandom_range(1, 60);
      steady = (phase == 4);
      if (steady && n < 150) n = 150;
      mode = $urandom_range(0, 3);
      base = $urandom_range(0, LEVELS - 1);
      for (int i = 0; i < n; i++) sample_q.push_back(pick_sample(mode, base, i));
      rand_items += n;
      phase++;
      wait_drained();
      steady = 1'b0;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (median_q.size() != 0) begin
      errors++;
      $display("%0t: %0d medians never arrived", $time, median_q.size());
    end
    $display("Sent %0d samples, checked %0d medians over %0d window settings",
             samples_sent, medians_seen, settings_used);
    $display("Window lengths from %0d to %0d, ties, extremes and mid-fill rewrites included",
             win_min, win_max_used);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

endmodule
